// File: sv/gtu_pkg.sv
package gtu_pkg;

  // per-path tag state
  typedef struct packed {
    logic [14:0] loops_left;
    logic [4:0]  regs_remaining;
    logic [4:0]  reg_total;
    logic [63:0] reg_list;
    logic [1:0]  fmt;
    logic        eop;
  } gtu_path_t;

  // one result transaction
  typedef struct packed {
    logic        write_valid;
    logic [7:0]  gs_addr;
    logic [63:0] gs_data;
    logic        last;
    logic        packet_done;
    logic        tag_loaded;
  } gtu_result_t;

  // transfer formats
  localparam logic [1:0] FMT_PACKED  = 2'd0;
  localparam logic [1:0] FMT_REGLIST = 2'd1;

  // register descriptors with special handling
  localparam logic [3:0] DESC_RGBAQ = 4'h1;
  localparam logic [3:0] DESC_ST    = 4'h2;
  localparam logic [3:0] DESC_UV    = 4'h3;
  localparam logic [3:0] DESC_XYZF2 = 4'h4;
  localparam logic [3:0] DESC_XYZ2  = 4'h5;
  localparam logic [3:0] DESC_FOG   = 4'hA;
  localparam logic [3:0] DESC_AD    = 4'hE;
  localparam logic [3:0] DESC_NOP   = 4'hF;

  // graphics register addresses
  localparam logic [7:0] ADDR_PRIM  = 8'h00;
  localparam logic [7:0] ADDR_RGBAQ = 8'h01;
  localparam logic [7:0] ADDR_ST    = 8'h02;
  localparam logic [7:0] ADDR_UV    = 8'h03;
  localparam logic [7:0] ADDR_XYZF2 = 8'h04;
  localparam logic [7:0] ADDR_XYZ2  = 8'h05;
  localparam logic [7:0] ADDR_FOG   = 8'h0A;
  localparam logic [7:0] ADDR_XYZF3 = 8'h0C;
  localparam logic [7:0] ADDR_XYZ3  = 8'h0D;
  localparam logic [7:0] ADDR_HWREG = 8'h54;

  // q reset value, 1.0 in single precision
  localparam logic [31:0] Q_ONE = 32'h3F80_0000;

endpackage

// File: sv/giftag_packet_unpacker_core.sv
// Tag and packet unpacker for the graphics interface.
// Input channel: one quadword per transaction (path_i, data_lo_i, data_hi_i),
// handshake in_valid_i / in_stall_o. Output channel: one register write per
// transaction (write_valid_o, gs_addr_o, gs_data_o, last_o, packet_done_o,
// tag_loaded_o), handshake out_valid_o / out_stall_i.
// A quadword is taken into an input register, then decoded against the tag
// state of its path and written to the result register. A second result
// (reglist and image data) is parked in a pending register and moves to
// the result register once the receiver takes the first.
// Throughput: one quadword per cycle when it gives one result and the
// receiver does not stall; a quadword that gives two results holds off the
// next decode until its second result leaves the pending register.
// While the receiver stalls, the result register holds and the input
// register fills, then in_stall_o rises.
// Reset clears all per-path tag state (every path then expects a tag),
// sets Q to 1.0 and empties both channels.
module giftag_packet_unpacker_core import gtu_pkg::*; #(
  parameter int NUM_PATHS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  path_i,
  input  logic [63:0] data_lo_i,
  input  logic [63:0] data_hi_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        write_valid_o,
  output logic [7:0]  gs_addr_o,
  output logic [63:0] gs_data_o,
  output logic        last_o,
  output logic        packet_done_o,
  output logic        tag_loaded_o
);

  localparam int PathW = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;

  logic        in_valid_q;
  logic [1:0]  path_q;
  logic [63:0] lo_q;
  logic [63:0] hi_q;
  gtu_path_t   st_q [NUM_PATHS];
  logic [31:0] q_val_q;
  logic        o_valid_q;
  gtu_result_t o_q;
  logic        p_valid_q;
  gtu_result_t p_q;

  logic             path_ok;
  logic [PathW-1:0] idx;
  gtu_path_t        st_cur;
  gtu_path_t        st_nxt;
  logic             q_we;
  logic [31:0]      q_nxt;
  gtu_result_t      res0;
  gtu_result_t      res1;
  logic             two;
  logic             out_free;
  logic             consume;
  logic             accept;

  // handshake control
  assign out_free   = !o_valid_q || !out_stall_i;
  assign consume    = in_valid_q && out_free && !p_valid_q;
  assign in_stall_o = in_valid_q && !consume;
  assign accept     = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      path_q <= path_i;
      lo_q   <= data_lo_i;
      hi_q   <= data_hi_i;
    end
  end

  // path select
  assign path_ok = (32'(path_q) < NUM_PATHS);
  assign idx     = PathW'(path_q);
  assign st_cur  = st_q[idx];

  gtu_unpack u_unpack (
    .path_ok_i (path_ok),
    .st_i      (st_cur),
    .q_i       (q_val_q),
    .lo_i      (lo_q),
    .hi_i      (hi_q),
    .st_o      (st_nxt),
    .q_we_o    (q_we),
    .q_o       (q_nxt),
    .res0_o    (res0),
    .res1_o    (res1),
    .two_o     (two)
  );

  // tag state and shared q
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PATHS; i++) begin
        st_q[i] <= '0;
      end
      q_val_q <= Q_ONE;
    end else if (consume) begin
      if (path_ok) begin
        st_q[idx] <= st_nxt;
      end
      if (q_we) begin
        q_val_q <= q_nxt;
      end
    end
  end

  // result and pending register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      p_valid_q <= 1'b0;
    end else if (out_free) begin
      if (p_valid_q) begin
        o_valid_q <= 1'b1;
        p_valid_q <= 1'b0;
      end else if (consume) begin
        o_valid_q <= 1'b1;
        p_valid_q <= two;
      end else begin
        o_valid_q <= 1'b0;
      end
    end
  end

  // result and pending payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (p_valid_q) begin
        o_q <= p_q;
      end else if (consume) begin
        o_q <= res0;
        p_q <= res1;
      end
    end
  end

  assign out_valid_o   = o_valid_q;
  assign write_valid_o = o_q.write_valid;
  assign gs_addr_o     = o_q.gs_addr;
  assign gs_data_o     = o_q.gs_data;
  assign last_o        = o_q.last;
  assign packet_done_o = o_q.packet_done;
  assign tag_loaded_o  = o_q.tag_loaded;

`ifndef SYNTHESIS
  // a parked second result always sits behind a shown first one
  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q |-> o_valid_q)
    else $error("pending result without result register");

  // the first of two results is never the last of its quadword
  a_pend_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q |-> !o_q.last)
    else $error("first of two results marked last");

  // no new quadword is decoded while a second result waits
  a_no_decode_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q |-> !consume)
    else $error("quadword decoded over a pending result");

  // a two-result quadword parks its second result
  a_two_parks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && two) |=> p_valid_q)
    else $error("second result lost");
`endif

endmodule

// File: sv/gtu_unpack.sv
module gtu_unpack import gtu_pkg::*; (
  input  logic        path_ok_i,
  input  gtu_path_t   st_i,
  input  logic [31:0] q_i,
  input  logic [63:0] lo_i,
  input  logic [63:0] hi_i,
  output gtu_path_t   st_o,
  output logic        q_we_o,
  output logic [31:0] q_o,
  output gtu_result_t res0_o,
  output gtu_result_t res1_o,
  output logic        two_o
);

  // descriptor at the current register position
  function automatic logic [3:0] cur_desc(gtu_path_t s);
    logic [3:0] idx;
    idx = s.reg_total[3:0] - s.regs_remaining[3:0];
    return s.reg_list[{idx, 2'b00} +: 4];
  endfunction

  // step to the next register, closing a loop on the last one
  function automatic gtu_path_t advance(gtu_path_t s);
    gtu_path_t n;
    n = s;
    if (s.regs_remaining == 5'd1) begin
      n.regs_remaining = s.reg_total;
      n.loops_left     = s.loops_left - 15'd1;
    end else begin
      n.regs_remaining = s.regs_remaining - 5'd1;
    end
    return n;
  endfunction

  // keep top 24 bits, saturate inf and nan to max magnitude
  function automatic logic [31:0] clamp(logic [31:0] v);
    logic [31:0] t;
    t = {v[31:8], 8'h00};
    if (t[30:23] == 8'hFF) begin
      t = {t[31], 31'h7F7F_FFFF};
    end
    return t;
  endfunction

  function automatic gtu_result_t mk(logic we, logic [7:0] a, logic [63:0] d);
    gtu_result_t r;
    r             = '0;
    r.write_valid = we;
    r.gs_addr     = we ? a : 8'h00;
    r.gs_data     = we ? d : 64'h0;
    return r;
  endfunction

  gtu_path_t  s1;
  gtu_path_t  s2;
  logic [3:0] d0;
  logic [3:0] d1;
  logic       nokick;
  logic       is_tag;
  logic [3:0] nregs;

  assign s1     = advance(st_i);
  assign s2     = advance(s1);
  assign d0     = cur_desc(st_i);
  assign d1     = cur_desc(s1);
  assign nokick = hi_i[47];
  assign is_tag = (st_i.loops_left == 15'd0);
  assign nregs  = lo_i[63:60];

  always_comb begin
    st_o   = st_i;
    q_we_o = 1'b0;
    q_o    = Q_ONE;
    res0_o = mk(1'b0, 8'h00, 64'h0);
    res1_o = mk(1'b0, 8'h00, 64'h0);
    two_o  = 1'b0;

    if (!path_ok_i) begin
      // unknown path: empty result, nothing changes
      res0_o.last = 1'b1;
    end else if (is_tag) begin
      // tag load
      st_o.loops_left     = lo_i[14:0];
      st_o.eop            = lo_i[15];
      st_o.fmt            = lo_i[59:58];
      st_o.reg_total      = (nregs == 4'd0) ? 5'd16 : {1'b0, nregs};
      st_o.regs_remaining = (nregs == 4'd0) ? 5'd16 : {1'b0, nregs};
      st_o.reg_list       = hi_i;
      q_we_o              = 1'b1;
      q_o                 = Q_ONE;
      res0_o = mk(lo_i[46] && (lo_i[59:58] == FMT_PACKED) && (lo_i[14:0] != 15'd0),
                  ADDR_PRIM, 64'(lo_i[57:47]));
      res0_o.last        = 1'b1;
      res0_o.tag_loaded  = 1'b1;
      res0_o.packet_done = (lo_i[14:0] == 15'd0) && lo_i[15];
    end else if (st_i.fmt == FMT_PACKED) begin
      // packed: at most one repacked write per quadword
      st_o = s1;
      case (d0)
        DESC_RGBAQ: res0_o = mk(1'b1, ADDR_RGBAQ,
                                {q_i, hi_i[39:32], hi_i[7:0], lo_i[39:32], lo_i[7:0]});
        DESC_ST: begin
          q_we_o = 1'b1;
          q_o    = clamp(hi_i[31:0]);
          res0_o = mk(1'b1, ADDR_ST, {clamp(lo_i[63:32]), clamp(lo_i[31:0])});
        end
        DESC_UV:    res0_o = mk(1'b1, ADDR_UV,
                                {32'h0, 2'b00, lo_i[45:32], 2'b00, lo_i[13:0]});
        DESC_XYZF2: res0_o = mk(1'b1, nokick ? ADDR_XYZF3 : ADDR_XYZF2,
                                {hi_i[43:36], hi_i[27:4], lo_i[47:32], lo_i[15:0]});
        DESC_XYZ2:  res0_o = mk(1'b1, nokick ? ADDR_XYZ3 : ADDR_XYZ2,
                                {hi_i[31:0], lo_i[47:32], lo_i[15:0]});
        DESC_FOG:   res0_o = mk(1'b1, ADDR_FOG, {hi_i[43:36], 56'h0});
        DESC_AD:    res0_o = mk(1'b1, hi_i[7:0], lo_i);
        DESC_NOP:   res0_o = mk(1'b0, 8'h00, 64'h0);
        default:    res0_o = mk(1'b1, {4'h0, d0}, lo_i);
      endcase
      res0_o.last        = 1'b1;
      res0_o.packet_done = (s1.loops_left == 15'd0) && st_i.eop;
    end else if (st_i.fmt == FMT_REGLIST) begin
      // reglist: two raw writes, odd tail dropped at the end of the loops, AD slots not written
      res0_o = mk(d0 != DESC_AD, {4'h0, d0}, lo_i);
      if ((st_i.regs_remaining == 5'd1) && (s1.loops_left == 15'd0)) begin
        st_o               = s1;
        res0_o.last        = 1'b1;
        res0_o.packet_done = st_i.eop;
      end else begin
        st_o               = s2;
        two_o              = 1'b1;
        res1_o             = mk(d1 != DESC_AD, {4'h0, d1}, hi_i);
        res1_o.last        = 1'b1;
        res1_o.packet_done = (s2.loops_left == 15'd0) && st_i.eop;
      end
    end else begin
      // image: both halves to the host transfer register
      st_o.loops_left    = st_i.loops_left - 15'd1;
      two_o              = 1'b1;
      res0_o             = mk(1'b1, ADDR_HWREG, lo_i);
      res1_o             = mk(1'b1, ADDR_HWREG, hi_i);
      res1_o.last        = 1'b1;
      res1_o.packet_done = (st_o.loops_left == 15'd0) && st_i.eop;
    end
  end

endmodule
